>>> hw/rtl/bdc_pkg.sv
// bdc_pkg: shared types and constants for the de casteljau bezier evaluator
// command and result codes, the fixed-point constants, and the controller to datapath struct
// no dependencies
`default_nettype none

package bdc_pkg;

  // item command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_EVAL   = 2'd3
  } cmd_code_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_CURVE = 2'd0,
    ST_FEW   = 2'd1,
    ST_DONE  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam int COORD_W  = 12;
  localparam int FRAC_W   = 4;
  localparam int FIX_W    = COORD_W + FRAC_W;
  localparam int T_W      = 17;
  localparam int T_FRAC_W = 16;

  localparam logic [T_W-1:0] T_ONE = 17'h10000;
  localparam int MIN_CURVE_POINTS = 3;

  // product of a 17-bit unsigned t and a 17-bit signed difference
  localparam int PROD_W = (T_W + 1) + (FIX_W + 1);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  // commands from the controller to the datapath
  typedef struct packed {
    logic ctrl_wr;      // append point to the control store
    logic load_t;       // capture the curve parameter
    logic rd_en;        // read one point for the lerp stream
    logic rd_first;     // first read of a pass, nothing to interpolate yet
    logic rd_src_ctrl;  // first pass reads the control store
    logic emit_curve;   // load output with the curve point
    logic emit_zero;    // load output with zero
  } dp_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/bdc_ram.sv
// bdc_ram: generic single write port, single read port RAM with registered read
// no dependencies
`default_nettype none

module bdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bdc_datapath.sv
// bdc_datapath: control and work stores, the shared two-axis lerp pipeline, output point
// depends on bdc_pkg and bdc_ram
`default_nettype none

module bdc_datapath
  import bdc_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dp_cmd_t                       cmd,
  input  wire logic [$clog2(MAX_POINTS)-1:0] ctrl_wr_addr,
  input  wire logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  input  wire logic [COORD_W-1:0]            point_x,
  input  wire logic [COORD_W-1:0]            point_y,
  input  wire logic [T_W-1:0]                t_position,
  output logic                               pipe_busy,
  output logic      [FIX_W-1:0]              curve_x,
  output logic      [FIX_W-1:0]              curve_y
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  logic [T_W-1:0]         t_sat;
  logic [2*COORD_W-1:0]   ctrl_rdata;
  logic [2*FIX_W-1:0]     work_rdata;

  logic                   s0_vld;
  logic                   s0_first;
  logic                   s0_src;
  logic [IDX_W-1:0]       s0_addr;
  logic [2*FIX_W-1:0]     s0_point;
  logic [2*FIX_W-1:0]     prev;

  logic                   s1_vld;
  logic [IDX_W-1:0]       s1_addr;
  logic [FIX_W-1:0]       s1_px;
  logic [FIX_W-1:0]       s1_py;
  logic signed [PROD_W-1:0] s1_prod_x;
  logic signed [PROD_W-1:0] s1_prod_y;

  logic signed [FIX_W:0]  diff_x;
  logic signed [FIX_W:0]  diff_y;
  logic signed [T_W:0]    t_signed;
  logic signed [PROD_W-1:0] step_x;
  logic signed [PROD_W-1:0] step_y;
  logic [FIX_W-1:0]       res_x;
  logic [FIX_W-1:0]       res_y;
  logic [2*FIX_W-1:0]     last;

  bdc_ram #(
    .WIDTH(2 * COORD_W),
    .DEPTH(MAX_POINTS)
  ) u_ctrl_ram (
    .clk     (clk),
    .wr_en   (cmd.ctrl_wr),
    .wr_addr (ctrl_wr_addr),
    .wr_data ({point_x, point_y}),
    .rd_en   (cmd.rd_en & cmd.rd_src_ctrl),
    .rd_addr (rd_addr),
    .rd_data (ctrl_rdata)
  );

  bdc_ram #(
    .WIDTH(2 * FIX_W),
    .DEPTH(MAX_POINTS)
  ) u_work_ram (
    .clk     (clk),
    .wr_en   (s1_vld),
    .wr_addr (s1_addr),
    .wr_data ({res_x, res_y}),
    .rd_en   (cmd.rd_en & ~cmd.rd_src_ctrl),
    .rd_addr (rd_addr),
    .rd_data (work_rdata)
  );

  // control points enter as 12.4 with zero fraction
  always_comb begin
    if (s0_src) begin
      s0_point = {ctrl_rdata[2*COORD_W-1:COORD_W], {FRAC_W{1'b0}},
                  ctrl_rdata[COORD_W-1:0], {FRAC_W{1'b0}}};
    end else begin
      s0_point = work_rdata;
    end
  end

  assign t_signed = $signed({1'b0, t_sat});
  assign diff_x   = $signed({1'b0, s0_point[2*FIX_W-1:FIX_W]}) -
                    $signed({1'b0, prev[2*FIX_W-1:FIX_W]});
  assign diff_y   = $signed({1'b0, s0_point[FIX_W-1:0]}) -
                    $signed({1'b0, prev[FIX_W-1:0]});

  // round to nearest, halves upward: floor((t*d + half) / 2^16)
  assign step_x = (s1_prod_x + ROUND_HALF) >>> T_FRAC_W;
  assign step_y = (s1_prod_y + ROUND_HALF) >>> T_FRAC_W;
  assign res_x  = s1_px + step_x[FIX_W-1:0];
  assign res_y  = s1_py + step_y[FIX_W-1:0];

  assign pipe_busy = s0_vld | s1_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
    end else begin
      s0_vld <= cmd.rd_en;
      s1_vld <= s0_vld & ~s0_first;
    end

    if (cmd.load_t) begin
      t_sat <= (t_position > T_ONE) ? T_ONE : t_position;
    end

    s0_first <= cmd.rd_first;
    s0_src   <= cmd.rd_src_ctrl;
    s0_addr  <= rd_addr;

    if (s0_vld) begin
      prev <= s0_point;
    end

    if (s0_vld && !s0_first) begin
      s1_prod_x <= PROD_W'(t_signed) * PROD_W'(diff_x);
      s1_prod_y <= PROD_W'(t_signed) * PROD_W'(diff_y);
      s1_px     <= prev[2*FIX_W-1:FIX_W];
      s1_py     <= prev[FIX_W-1:0];
      s1_addr   <= s0_addr - IDX_W'(1);
    end

    // the only write of the final pass is the curve point
    if (s1_vld) begin
      last <= {res_x, res_y};
    end

    if (cmd.emit_curve) begin
      curve_x <= last[2*FIX_W-1:FIX_W];
      curve_y <= last[FIX_W-1:0];
    end else if (cmd.emit_zero) begin
      curve_x <= '0;
      curve_y <= '0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bdc_controller.sv
// bdc_controller: command decode, point count and the pass sequencer for evaluation
// depends on bdc_pkg
`default_nettype none

module bdc_controller
  import bdc_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [1:0]                      command,
  input  wire logic                            pipe_busy,
  output logic                                 busy,
  output logic                                 done,
  output logic      [1:0]                      status,
  output logic      [$clog2(MAX_POINTS+1)-1:0] point_count,
  output dp_cmd_t                              cmd,
  output logic      [$clog2(MAX_POINTS)-1:0]   ctrl_wr_addr,
  output logic      [$clog2(MAX_POINTS)-1:0]   rd_addr
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS,
    S_DRAIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pass_len;
  logic [IDX_W-1:0] rd_idx;
  logic             first_pass;
  status_t          status_q;

  logic             accept;
  logic             has_room;
  logic             enough;
  logic             last_read;
  logic             pass_done;

  assign accept    = start && (state == S_IDLE);
  assign has_room  = count < CNT_W'(MAX_POINTS);
  assign enough    = count >= CNT_W'(MIN_CURVE_POINTS);
  assign last_read = CNT_W'(rd_idx) == pass_len - CNT_W'(1);
  assign pass_done = (state == S_DRAIN) && !pipe_busy;

  assign busy         = (state != S_IDLE);
  assign status       = status_q;
  assign point_count  = count;
  assign rd_addr      = rd_idx;
  assign ctrl_wr_addr = count[IDX_W-1:0];

  always_comb begin
    cmd.ctrl_wr     = accept && (cmd_code_t'(command) == CMD_APPEND) && has_room;
    cmd.load_t      = accept && (cmd_code_t'(command) == CMD_EVAL);
    cmd.rd_en       = (state == S_PASS);
    cmd.rd_first    = (rd_idx == '0);
    cmd.rd_src_ctrl = first_pass;
    cmd.emit_curve  = pass_done && (pass_len == CNT_W'(2));
    cmd.emit_zero   = accept && !((cmd_code_t'(command) == CMD_EVAL) && enough);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      done       <= 1'b0;
      status_q   <= ST_DONE;
      pass_len   <= '0;
      rd_idx     <= '0;
      first_pass <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd_code_t'(command))
              CMD_CLEAR: begin
                count    <= '0;
                status_q <= ST_DONE;
                done     <= 1'b1;
              end
              CMD_APPEND: begin
                if (has_room) begin
                  count    <= count + CNT_W'(1);
                  status_q <= ST_DONE;
                end else begin
                  status_q <= ST_FULL;
                end
                done <= 1'b1;
              end
              CMD_REMOVE: begin
                if (count != '0) begin
                  count <= count - CNT_W'(1);
                end
                status_q <= ST_DONE;
                done     <= 1'b1;
              end
              CMD_EVAL: begin
                if (enough) begin
                  pass_len   <= count;
                  rd_idx     <= '0;
                  first_pass <= 1'b1;
                  state      <= S_PASS;
                end else begin
                  status_q <= ST_FEW;
                  done     <= 1'b1;
                end
              end
              default: begin
                status_q <= ST_DONE;
                done     <= 1'b1;
              end
            endcase
          end
        end
        S_PASS: begin
          if (last_read) begin
            state <= S_DRAIN;
          end else begin
            rd_idx <= rd_idx + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          // next pass starts only once every write of this one has landed
          if (!pipe_busy) begin
            if (pass_len == CNT_W'(2)) begin
              status_q <= ST_CURVE;
              done     <= 1'b1;
              state    <= S_IDLE;
            end else begin
              pass_len   <= pass_len - CNT_W'(1);
              rd_idx     <= '0;
              first_pass <= 1'b0;
              state      <= S_PASS;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bezier_de_casteljau_evaluator_core.sv
// bezier_de_casteljau_evaluator_core: top level, controller plus datapath
// depends on bdc_pkg, bdc_controller, bdc_datapath (and bdc_ram below it)
//
//   channel   handshake            payload
//   command   start / busy         command, point_x, point_y, t_position
//   result    done (one cycle)     curve_x, curve_y, status, point_count
//
// clear, append and remove: the result shows in the cycle after the transfer
// evaluate with n points keeps busy high until its result shows;
//   one shared lerp unit streams each pass of n..2 points and drains between passes
// fewer than three points gives the result in the next cycle with busy left low
// rst is synchronous and empties the store; the result side has no back-pressure
`default_nettype none

module bezier_de_casteljau_evaluator_core
  import bdc_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          command,
  input  wire logic [COORD_W-1:0]                  point_x,
  input  wire logic [COORD_W-1:0]                  point_y,
  input  wire logic [T_W-1:0]                      t_position,
  output logic                                     done,
  output logic      [FIX_W-1:0]                    curve_x,
  output logic      [FIX_W-1:0]                    curve_y,
  output logic      [1:0]                          status,
  output logic      [$clog2(MAX_POINTS+1)-1:0]     point_count
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  dp_cmd_t          cmd;
  logic             pipe_busy;
  logic [IDX_W-1:0] ctrl_wr_addr;
  logic [IDX_W-1:0] rd_addr;

  bdc_controller #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .pipe_busy    (pipe_busy),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .point_count  (point_count),
    .cmd          (cmd),
    .ctrl_wr_addr (ctrl_wr_addr),
    .rd_addr      (rd_addr)
  );

  bdc_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .ctrl_wr_addr (ctrl_wr_addr),
    .rd_addr      (rd_addr),
    .point_x      (point_x),
    .point_y      (point_y),
    .t_position   (t_position),
    .pipe_busy    (pipe_busy),
    .curve_x      (curve_x),
    .curve_y      (curve_y)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking testbench for bezier_de_casteljau_evaluator_core
// drives store edits and curve evaluations, predicts each result and checks every done strobe
// depends on bdc_pkg and the evaluator rtl
`timescale 1ns / 1ps

module tb_top;
  import bdc_pkg::*;

  localparam int MAXP = 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int ITEMS_PER_BATCH = 350;

  typedef struct {
    cmd_code_t          cmd;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [T_W-1:0]     tp;
  } bez_item_t;

  typedef struct {
    logic [FIX_W-1:0] cx;
    logic [FIX_W-1:0] cy;
    status_t          st;
    logic [4:0]       cnt;
  } curve_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] command = CMD_CLEAR;
  logic [COORD_W-1:0] point_x = '0;
  logic [COORD_W-1:0] point_y = '0;
  logic [T_W-1:0] t_position = '0;
  logic busy;
  logic done;
  logic [FIX_W-1:0] curve_x;
  logic [FIX_W-1:0] curve_y;
  logic [1:0] status;
  logic [4:0] point_count;

  bez_item_t     pending_q[$];
  curve_result_t curve_expect_q[$];
  bez_item_t     in_flight;
  int            gap_left = 0;
  bit            no_gaps = 1'b0;
  int            items_queued = 0;
  int            errors = 0;
  int            cycles = 0;

  // predictor copy of the point store
  logic [COORD_W-1:0] ctrl_x[MAXP];
  logic [COORD_W-1:0] ctrl_y[MAXP];
  int                 held = 0;

  bezier_de_casteljau_evaluator_core #(.MAX_POINTS(MAXP)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .point_x(point_x),
    .point_y(point_y),
    .t_position(t_position),
    .done(done),
    .curve_x(curve_x),
    .curve_y(curve_y),
    .status(status),
    .point_count(point_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // p + round(t*(q-p)), halves toward plus infinity
  function automatic logic [FIX_W-1:0] lerp_fix(logic [FIX_W-1:0] p, logic [FIX_W-1:0] q,
                                                logic [T_W-1:0] t);
    longint d;
    longint v;
    d = longint'(q) - longint'(p);
    v = longint'(t) * d + 32768;
    return FIX_W'(longint'(p) + (v >>> 16));
  endfunction

  function automatic curve_result_t apply_command(bez_item_t it);
    curve_result_t r;
    logic [T_W-1:0] tc;
    logic [FIX_W-1:0] wx[MAXP];
    logic [FIX_W-1:0] wy[MAXP];
    r.cx = '0;
    r.cy = '0;
    r.st = ST_DONE;
    tc = (it.tp > T_ONE) ? T_ONE : it.tp;
    case (it.cmd)
      CMD_CLEAR: held = 0;
      CMD_APPEND: begin
        if (held < MAXP) begin
          ctrl_x[held] = it.px;
          ctrl_y[held] = it.py;
          held++;
        end else begin
          r.st = ST_FULL;
        end
      end
      CMD_REMOVE: if (held > 0) held--;
      default: begin
        if (held < MIN_CURVE_POINTS) begin
          r.st = ST_FEW;
        end else begin
          for (int i = 0; i < held; i++) begin
            wx[i] = {ctrl_x[i], 4'd0};
            wy[i] = {ctrl_y[i], 4'd0};
          end
          for (int rr = 1; rr < held; rr++)
            for (int i = 0; i + rr < held; i++) begin
              wx[i] = lerp_fix(wx[i], wx[i+1], tc);
              wy[i] = lerp_fix(wy[i], wy[i+1], tc);
            end
          r.cx = wx[0];
          r.cy = wy[0];
          r.st = ST_CURVE;
        end
      end
    endcase
    r.cnt = 5'(held);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[cycle %0d] mismatch: %s", cycles, what);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // t spread over the whole 17-bit field, values above one saturate
  function automatic logic [T_W-1:0] pick_param();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return T_ONE;
      2: return T_W'($urandom_range(65537, 131071));
      3: return T_W'($urandom_range(0, 255));
      default: return T_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic void enqueue(cmd_code_t c, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [T_W-1:0] tp);
    bez_item_t it;
    it.cmd = c;
    it.px = x;
    it.py = y;
    it.tp = tp;
    pending_q = {pending_q, it};
    items_queued++;
  endfunction

  // mostly build-then-evaluate runs with random content, the rest noise
  function automatic void queue_random_run();
    int npts;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 3) != 0) enqueue(CMD_CLEAR, pick_coord(), pick_coord(), pick_param());
      npts = ($urandom_range(0, 7) == 0) ? $urandom_range(14, MAXP + 2) : $urandom_range(3, 8);
      repeat (npts) enqueue(CMD_APPEND, pick_coord(), pick_coord(), pick_param());
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 5) == 0) enqueue(CMD_REMOVE, pick_coord(), pick_coord(), pick_param());
        enqueue(CMD_EVAL, pick_coord(), pick_coord(), pick_param());
      end
    end else begin
      repeat ($urandom_range(1, 5))
        enqueue(cmd_code_t'(2'($urandom_range(0, 3))), pick_coord(), pick_coord(), pick_param());
    end
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || start || curve_expect_q.size() != 0) @(negedge clk);
  endtask

  // driver: one transfer per edge with start high and busy low
  always @(posedge clk) begin : driver_proc
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) curve_expect_q = {curve_expect_q, apply_command(in_flight)};
      if (start && busy) begin
        // hold the item until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_flight = pending_q.pop_front();
        command <= in_flight.cmd;
        point_x <= in_flight.px;
        point_y <= in_flight.py;
        t_position <= in_flight.tp;
        start <= 1'b1;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor_proc
    curve_result_t e;
    if (!rst && done) begin
      if (curve_expect_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, status %0d", status));
      end else begin
        e = curve_expect_q.pop_front();
        if (curve_x !== e.cx)
          report_mismatch($sformatf("curve_x got %0h want %0h", curve_x, e.cx));
        if (curve_y !== e.cy)
          report_mismatch($sformatf("curve_y got %0h want %0h", curve_y, e.cy));
        if (status !== e.st)
          report_mismatch($sformatf("status got %0d want %0d", status, e.st));
        if (point_count !== e.cnt)
          report_mismatch($sformatf("point_count got %0d want %0d", point_count, e.cnt));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, too few points, a full store, parameter extremes and saturation
    enqueue(CMD_EVAL, '0, '0, T_ONE);
    enqueue(CMD_REMOVE, '1, '1, '1);
    enqueue(CMD_APPEND, '0, '0, '0);
    enqueue(CMD_APPEND, '1, '1, '1);
    enqueue(CMD_EVAL, '0, '0, 17'h08000);
    enqueue(CMD_APPEND, '1, '0, '0);
    enqueue(CMD_EVAL, '0, '0, '0);
    enqueue(CMD_EVAL, '0, '0, T_ONE);
    enqueue(CMD_EVAL, '1, '1, '1);
    enqueue(CMD_EVAL, '0, '0, 17'h08000);
    enqueue(CMD_EVAL, '0, '0, 17'd1);
    enqueue(CMD_EVAL, '0, '0, 17'h0ffff);
    enqueue(CMD_REMOVE, '0, '0, '0);
    enqueue(CMD_EVAL, '0, '0, 17'h08000);
    enqueue(CMD_APPEND, 12'haaa, 12'h555, 17'h15555);
    enqueue(CMD_APPEND, 12'h555, 12'haaa, 17'h0aaaa);
    enqueue(CMD_EVAL, 12'haaa, 12'h555, 17'h15555);
    enqueue(CMD_EVAL, 12'h555, 12'haaa, 17'h0aaaa);
    enqueue(CMD_CLEAR, '1, '1, '1);
    enqueue(CMD_EVAL, '0, '0, 17'h08000);
    for (int k = 0; k < MAXP + 1; k++) enqueue(CMD_APPEND, pick_coord(), pick_coord(), '0);
    enqueue(CMD_EVAL, '0, '0, 17'h04000);
    // sender holds off until every outstanding result is back
    wait_drained();

    for (int b = 0; b < 4; b++) begin
      no_gaps = (b == 2);
      while (items_queued < 40 + (b + 1) * ITEMS_PER_BATCH) queue_random_run();
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/bdc_pkg.sv
hw/rtl/bdc_ram.sv
hw/rtl/bdc_datapath.sv
hw/rtl/bdc_controller.sv
hw/rtl/bezier_de_casteljau_evaluator_core.sv
tb/tb_top.sv
